// ===== sv/eas_pkg.sv =====
// ----------------------------------------------------------------------------
// eas_pkg
// Shared types, codes and defaults of the expect/abort string matcher.
// ----------------------------------------------------------------------------
package eas_pkg;

  // Default configuration of the top level
  localparam int PATTERN_BYTES_DEF = 8;
  localparam int ABORT_SLOTS_DEF   = 4;

  // Fixed register widths
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int LENS_W    = 16;
  localparam int TMO_W     = 16;
  localparam int POS_W     = 3;
  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;
  localparam int MAX_SLOTS = 4;

  localparam logic [TMO_W-1:0] TIMEOUT_DEF = 16'd30;
  localparam logic [LEN_W-1:0] EXPECT_LEN_DEF = 4'd1;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_EXPECT_PATTERN  = 3'd0;
  localparam logic [2:0] REG_EXPECT_LEN      = 3'd1;
  localparam logic [2:0] REG_ABORT_PATTERN_0 = 3'd2;
  localparam logic [2:0] REG_ABORT_LENS      = 3'd6;
  localparam logic [2:0] REG_TIMEOUT_SEC     = 3'd7;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_WAIT    = 2'd0,
    STAT_EXPECT  = 2'd1,
    STAT_ABORT   = 2'd2,
    STAT_TIMEOUT = 2'd3
  } status_t;

endpackage

// ===== sv/eas_if.sv =====
// ----------------------------------------------------------------------------
// eas_in_if / eas_out_if
// Valid/ready channels of the matcher: received items in, results out.
// ----------------------------------------------------------------------------
interface eas_in_if;
  logic             valid;
  logic             ready;
  eas_pkg::opcode_t opcode;
  logic [7:0]       rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface eas_out_if;
  logic             valid;
  logic             ready;
  eas_pkg::status_t status;
  logic [1:0]       abort_index;

  modport source (output valid, output status, output abort_index, input ready);
  modport sink   (input valid, input status, input abort_index, output ready);
endinterface

// ===== sv/expect_abort_string_matcher.sv =====
// ----------------------------------------------------------------------------
// expect_abort_string_matcher
// Watches a byte stream for one expected string and several abort strings,
// with an idle-seconds timeout.
// ----------------------------------------------------------------------------
// Each input transaction is a received byte or a one-second tick; each one
// yields exactly one result transaction (waiting, expect matched, abort
// matched or timeout). The block takes one transaction per clock cycle
// sustained while the result side is not stalled. An accepted transaction
// is held in the input register, evaluated against the match state in a
// single pass and registered in the result register, which offers it. The
// per-cycle rate is set by the state update loop: match position, byte
// history and idle count are all rewritten in the same cycle that the
// result is formed.
// A stalled result register holds the pipeline; the input register still
// fills behind it.
// Configuration is an APB-style port with 64-bit data; register i sits at
// byte address 8*i. Write configuration only while no transaction is in
// flight. Any match, abort or timeout clears position, history and idle
// count.
// ----------------------------------------------------------------------------
module expect_abort_string_matcher #(
  parameter int PATTERN_BYTES = eas_pkg::PATTERN_BYTES_DEF,
  parameter int ABORT_SLOTS   = eas_pkg::ABORT_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  eas_in_if.sink                      in_ch,
  eas_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [eas_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [eas_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [eas_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int HIST_W = 8 * PATTERN_BYTES;
  localparam logic [eas_pkg::LEN_W-1:0] PB_LEN = eas_pkg::LEN_W'(PATTERN_BYTES);
  localparam logic [eas_pkg::TMO_W-1:0] IDLE_MAX = '1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [eas_pkg::PAT_W-1:0]  expect_pat_r;
  logic [eas_pkg::LEN_W-1:0]  expect_len_r;
  logic [eas_pkg::PAT_W-1:0]  abort_pat_r [ABORT_SLOTS];
  logic [eas_pkg::LENS_W-1:0] abort_lens_r;
  logic [eas_pkg::TMO_W-1:0]  timeout_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_pat_r <= '0;
      expect_len_r <= eas_pkg::EXPECT_LEN_DEF;
      abort_lens_r <= '0;
      timeout_r    <= eas_pkg::TIMEOUT_DEF;
      for (int i = 0; i < ABORT_SLOTS; i++) abort_pat_r[i] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        eas_pkg::REG_EXPECT_PATTERN: expect_pat_r <= cfg_pwdata;
        eas_pkg::REG_EXPECT_LEN:     expect_len_r <= cfg_pwdata[eas_pkg::LEN_W-1:0];
        eas_pkg::REG_ABORT_LENS:     abort_lens_r <= cfg_pwdata[eas_pkg::LENS_W-1:0];
        eas_pkg::REG_TIMEOUT_SEC:    timeout_r    <= cfg_pwdata[eas_pkg::TMO_W-1:0];
        default: ;
      endcase
      for (int i = 0; i < ABORT_SLOTS; i++) begin
        if (cfg_idx == eas_pkg::REG_ABORT_PATTERN_0 + 3'(i)) abort_pat_r[i] <= cfg_pwdata;
      end
    end
  end

  // Read back; abort slots not built read as zero
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      eas_pkg::REG_EXPECT_PATTERN: cfg_prdata = expect_pat_r;
      eas_pkg::REG_EXPECT_LEN:     cfg_prdata = eas_pkg::PDATA_W'(expect_len_r);
      eas_pkg::REG_ABORT_LENS:     cfg_prdata = eas_pkg::PDATA_W'(abort_lens_r);
      eas_pkg::REG_TIMEOUT_SEC:    cfg_prdata = eas_pkg::PDATA_W'(timeout_r);
      default: begin
        for (int i = 0; i < ABORT_SLOTS; i++) begin
          if (cfg_idx == eas_pkg::REG_ABORT_PATTERN_0 + 3'(i)) cfg_prdata = abort_pat_r[i];
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register -> result register
  // --------------------------------------------------------------------------
  logic             s1_valid_r;
  eas_pkg::opcode_t s1_op_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r;
  eas_pkg::status_t out_status_r;
  logic [1:0]       out_idx_r;

  logic in_acc;
  logic s1_adv;

  // Advance the input register whenever the result register is free or drains
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc || (s1_valid_r && !s1_adv);
      out_valid_r <= s1_adv || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_ch.opcode;
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Match state
  // --------------------------------------------------------------------------
  logic [eas_pkg::POS_W-1:0] match_pos_r, match_pos_nxt;
  logic [HIST_W-1:0]         hist_r, hist_nxt;
  logic [eas_pkg::LEN_W-1:0] hcnt_r, hcnt_nxt;
  logic [eas_pkg::TMO_W-1:0] idle_r, idle_nxt;
  eas_pkg::status_t          status_nxt;
  logic [1:0]                idx_nxt;

  // Byte path terms
  logic [HIST_W-1:0]         hist_shift;
  logic [eas_pkg::LEN_W-1:0] hcnt_inc;
  logic [eas_pkg::LEN_W-1:0] elen;
  logic [7:0]                exp_byte;
  logic                      exp_hit;
  logic [eas_pkg::LEN_W-1:0] pos_inc;
  logic                      exp_done;
  logic [eas_pkg::POS_W-1:0] pos_after;
  logic [eas_pkg::LEN_W-1:0] alen [ABORT_SLOTS];
  logic [HIST_W-1:0]         tail [ABORT_SLOTS];
  logic [ABORT_SLOTS-1:0]    slot_hit;
  logic                      abort_hit;
  logic [1:0]                abort_idx;
  // Tick path terms
  logic [eas_pkg::TMO_W-1:0] idle_inc;
  logic [eas_pkg::TMO_W-1:0] limit;
  logic                      tmo_hit;

  always_comb begin
    // Shift the newest byte in on top; count saturates at the history depth
    hist_shift = {s1_byte_r, hist_r[HIST_W-1:8]};
    hcnt_inc   = (hcnt_r < PB_LEN) ? hcnt_r + 4'd1 : hcnt_r;

    elen = (expect_len_r > PB_LEN) ? PB_LEN : expect_len_r;
    if (elen == '0) elen = 4'd1;

    exp_byte  = expect_pat_r[{match_pos_r, 3'b000} +: 8];
    exp_hit   = (exp_byte == s1_byte_r);
    pos_inc   = {1'b0, match_pos_r} + 4'd1;
    exp_done  = exp_hit && (pos_inc >= elen);
    pos_after = exp_hit ? pos_inc[eas_pkg::POS_W-1:0] : '0;

    // Compare the newest alen bytes with each abort string
    for (int i = 0; i < ABORT_SLOTS; i++) begin
      alen[i] = abort_lens_r[4*i +: 4];
      if (alen[i] > PB_LEN) alen[i] = PB_LEN;
      tail[i] = hist_shift >> {4'(PB_LEN - alen[i]), 3'b000};
      slot_hit[i] = (alen[i] != '0) && (alen[i] <= hcnt_inc);
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        if ((4'(j) < alen[i]) && (tail[i][8*j +: 8] != abort_pat_r[i][8*j +: 8])) begin
          slot_hit[i] = 1'b0;
        end
      end
    end

    // Lowest slot wins; only tested when no partial expect match is pending
    abort_hit = 1'b0;
    abort_idx = '0;
    for (int i = ABORT_SLOTS - 1; i >= 0; i--) begin
      if (slot_hit[i]) begin
        abort_hit = 1'b1;
        abort_idx = 2'(i);
      end
    end
    abort_hit = abort_hit && !exp_done && (pos_after == '0);

    idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 16'd1;
    limit    = (timeout_r == '0) ? eas_pkg::TIMEOUT_DEF : timeout_r;
    tmo_hit  = (idle_inc >= limit);

    // Default: hold
    match_pos_nxt = match_pos_r;
    hist_nxt      = hist_r;
    hcnt_nxt      = hcnt_r;
    idle_nxt      = idle_r;
    status_nxt    = eas_pkg::STAT_WAIT;
    idx_nxt       = '0;

    if (s1_op_r == eas_pkg::OP_TICK) begin
      idle_nxt = idle_inc;
      if (tmo_hit) status_nxt = eas_pkg::STAT_TIMEOUT;
    end else begin
      match_pos_nxt = pos_after;
      hist_nxt      = hist_shift;
      hcnt_nxt      = hcnt_inc;
      idle_nxt      = '0;
      if (exp_done) begin
        status_nxt = eas_pkg::STAT_EXPECT;
      end else if (abort_hit) begin
        status_nxt = eas_pkg::STAT_ABORT;
        idx_nxt    = abort_idx;
      end
    end

    // Any result restarts the matcher
    if (status_nxt != eas_pkg::STAT_WAIT) begin
      match_pos_nxt = '0;
      hist_nxt      = '0;
      hcnt_nxt      = '0;
      idle_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_pos_r <= '0;
      hist_r      <= '0;
      hcnt_r      <= '0;
      idle_r      <= '0;
    end else if (s1_adv) begin
      match_pos_r <= match_pos_nxt;
      hist_r      <= hist_nxt;
      hcnt_r      <= hcnt_nxt;
      idle_r      <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= status_nxt;
      out_idx_r    <= idx_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.abort_index = out_idx_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (status_nxt != eas_pkg::STAT_WAIT)
    |=> (match_pos_r == '0) && (hcnt_r == '0) && (idle_r == '0))
    else $error("matcher state not cleared after a result");

  a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_op_r == eas_pkg::OP_BYTE) |=> (idle_r == '0))
    else $error("idle count not cleared by a received byte");

  a_hcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (hcnt_r <= PB_LEN))
    else $error("history count beyond history depth");

  a_idx_only_on_abort: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_idx_r != '0) |-> (out_status_r == eas_pkg::STAT_ABORT))
    else $error("abort index set without an abort result");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction lost at the input register");

endmodule
